// ===== rtl/gmm_pkg.sv =====
// Package: widths and constants for the modular multiplier.
`default_nettype none
package gmm_pkg;
  localparam int OperandWidthDef = 32;
  localparam int ModBits = 31;
  localparam logic [ModBits-1:0] ModReset = 31'd3329;
endpackage
`default_nettype wire

// ===== rtl/gmm_if.sv =====
// Interfaces: operand and result channels.
`default_nettype none
interface gmm_in_if;
  logic valid;
  logic ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface gmm_out_if;
  logic valid;
  logic ready;
  logic [30:0] product_mod;
  modport source (output valid, product_mod, input ready);
  modport sink (input valid, product_mod, output ready);
endinterface
`default_nettype wire

// ===== rtl/gmm_cell.sv =====
// Cell: one restoring remainder step, shift in one product bit.
`default_nettype none
module gmm_cell
  import gmm_pkg::*;
(
  input  wire logic [ModBits-1:0] rem_in,
  input  wire logic               bit_in,
  input  wire logic [ModBits-1:0] modulus,
  output logic      [ModBits-1:0] rem_out
);
  logic [ModBits:0] sh;
  logic [ModBits+1:0] diff;
  always_comb begin
    sh = {rem_in, bit_in};
    diff = {1'b0, sh} - {2'b00, modulus};
    rem_out = diff[ModBits+1] ? sh[ModBits-1:0] : diff[ModBits-1:0];
  end
endmodule
`default_nettype wire

// ===== rtl/generalized_mersenne_modmul.sv =====
// Top level: modular multiplier built on a chain of remainder cells.
//  channel  dir  words
//  in       in   operand_a, operand_b
//  out      out  product_mod
//  cfg      in   modulus (cfg_we, cfg_data)
// A word is captured on acceptance, multiplied in the MUL state, then runs through the chain
// of Cells remainder cells in the RUN state (Cells bits per cycle), and the DONE state loads
// the result, waiting while a held result is not taken; then the next word can be accepted.
// Reset clears the busy and valid flags and loads modulus 3329.
// A result held on a stalled output does not block acceptance of the next word.
`default_nettype none
module generalized_mersenne_modmul
  import gmm_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDef
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [ModBits-1:0] cfg_data,
  gmm_in_if.sink  in_ch,
  gmm_out_if.source out_ch
);
  localparam int PW = 2*OPERAND_WIDTH;
  localparam int Cells = 4;
  localparam int Steps = PW/Cells;
  localparam int CW = $clog2(Steps+1);

  typedef enum logic [1:0] {IDLE, MUL, RUN, DONE} state_t;
  state_t state;
  logic [ModBits-1:0] modulus;
  logic [OPERAND_WIDTH-1:0] a, b;
  logic [PW-1:0] prod;
  logic [ModBits-1:0] rem;
  logic [CW-1:0] cnt;
  logic [ModBits-1:0] chain [Cells+1];

  assign in_ch.ready = (state == IDLE);
  assign chain[0] = rem;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    gmm_cell u_cell (
      .rem_in(chain[i]), .bit_in(prod[PW-1-i]), .modulus(modulus),
      .rem_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModReset;
      state <= IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_data;
      if (out_ch.valid && out_ch.ready && state != DONE) out_ch.valid <= 1'b0;
      unique case (state)
        IDLE: if (in_ch.valid) begin
          a <= in_ch.operand_a[OPERAND_WIDTH-1:0];
          b <= in_ch.operand_b[OPERAND_WIDTH-1:0];
          state <= MUL;
        end
        MUL: begin
          prod <= PW'(a) * PW'(b);
          rem <= '0;
          cnt <= '0;
          state <= RUN;
        end
        RUN: begin
          rem <= chain[Cells];
          prod <= prod << Cells;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(Steps-1)) state <= DONE;
        end
        DONE: if (!out_ch.valid || out_ch.ready) begin
          out_ch.product_mod <= (modulus == '0) ? '0 : rem;
          out_ch.valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && modulus != '0) |-> rem < modulus) else $error("rem not reduced");
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> state == MUL) else $error("bad accept");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == DONE) else $error("spurious result");
`endif
endmodule
`default_nettype wire
